// ===== hw/rtl/htok_pkg.sv =====
// Shared types and codes for the HTTP request header tokenizer.
// Used by the front, queue, back, top level and checker files.
// No dependencies.
package htok_pkg;

	localparam int HTOK_QUEUE_DEPTH = 4;

	// result tags
	localparam logic [2:0] TAG_METHOD  = 3'd0;
	localparam logic [2:0] TAG_URI     = 3'd1;
	localparam logic [2:0] TAG_VERSION = 3'd2;
	localparam logic [2:0] TAG_NAME    = 3'd3;
	localparam logic [2:0] TAG_VALUE   = 3'd4;
	localparam logic [2:0] TAG_SEP     = 3'd5;
	localparam logic [2:0] TAG_DONE    = 3'd6;
	localparam logic [2:0] TAG_ERROR   = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_SPACE = 3'd1;
	localparam logic [2:0] ERR_NO_COLON = 3'd2;
	localparam logic [2:0] ERR_TOO_MANY = 3'd3;
	localparam logic [2:0] ERR_NUL      = 3'd4;

	// parse phases
	localparam logic [2:0] PH_METHOD  = 3'd0;
	localparam logic [2:0] PH_URI     = 3'd1;
	localparam logic [2:0] PH_VERSION = 3'd2;
	localparam logic [2:0] PH_NAME    = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;
	localparam logic [2:0] PH_VALUE   = 3'd5;
	localparam logic [2:0] PH_ERROR   = 3'd6;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	localparam logic [7:0] MAX_HEADERS_RESET = 8'd100;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] tag;
		logic [7:0] out_byte;
		logic [7:0] header_number;
		logic [2:0] error_code;
		logic       last_of_run;
	} out_item_t;

	// all results caused by one input item
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} pair_t;

endpackage

// ===== hw/rtl/http_request_header_tokenizer.sv =====
// Top level of the HTTP request header tokenizer.
// Depends on htok_pkg, htok_front, htok_queue and htok_back.
//
// Usage:
//   Input channel: drive item and push; the item is taken at a clock edge
//   with push high and full low. kind = 1 abandons the request in progress.
//   Result channel: while empty is low the oldest result is on result; it
//   is taken at a clock edge with pop high. A byte gives zero, one or two
//   results; last_of_run marks the final one of a byte.
//   Config channel: cfg_data is written to max_headers when cfg_valid is
//   high; cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   One byte is accepted per cycle while full is low. The edge taking a byte
//   writes its results to the queue as one pair; the output register loads it
//   once free, and its first result then shows on result. A byte with two
//   results takes two pops; a byte with none takes no queue slot.
//   The phase machine in the front part sets the one-byte-per-cycle rate.
// Reset and stall:
//   arst_n clears the parse state, the queue and the output register and
//   sets max_headers to 100. When pop stays low the queue fills (QUEUE_DEPTH
//   pairs) and full rises until results are taken.
module http_request_header_tokenizer
	import htok_pkg::*;
#(
	parameter int QUEUE_DEPTH = HTOK_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  logic       push,
	output logic       full,
	output out_item_t  result,
	output logic       empty,
	input  logic       pop,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic  accept;
	logic  pair_valid;
	pair_t pair;
	logic  q_rd;
	pair_t q_data;
	logic  q_nonempty;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	htok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_item    (item),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.pair       (pair)
	);

	htok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (pair_valid),
		.wr_data  (pair),
		.full     (full),
		.rd       (q_rd),
		.rd_data  (q_data),
		.nonempty (q_nonempty)
	);

	htok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== hw/rtl/htok_front.sv =====
// Front part: takes input items, runs the phase machine and builds the
// one or two results of a byte, if any, as a pair. Depends on htok_pkg.
module htok_front
	import htok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_item_t   in_item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output logic       pair_valid,
	output pair_t      pair
);

	typedef struct packed {
		logic       emit;
		out_item_t  item;
		logic [2:0] ph;
		logic       lhc;
	} ct_t;

	logic [2:0] phase_q;
	logic       cr_q;
	logic [7:0] hc_q;
	logic       lhc_q;
	logic [7:0] max_q;

	function automatic out_item_t mk(input logic [2:0] tag, input logic [7:0] b,
		input logic [7:0] hn, input logic [2:0] err);
		out_item_t it;
		it.tag           = tag;
		it.out_byte      = b;
		it.header_number = hn;
		it.error_code    = err;
		it.last_of_run   = 1'b0;
		return it;
	endfunction

	// content byte of the current part; may turn into the too-many-headers error
	function automatic ct_t content(input logic [2:0] ph, input logic lhc,
		input logic [7:0] hc, input logic [7:0] mx, input logic [7:0] b);
		ct_t c;
		c.emit = 1'b1;
		c.ph   = ph;
		c.lhc  = lhc;
		c.item = mk(TAG_METHOD, b, hc, ERR_NONE);
		unique case (ph)
			PH_METHOD:  c.item.tag = TAG_METHOD;
			PH_URI:     c.item.tag = TAG_URI;
			PH_VERSION: c.item.tag = TAG_VERSION;
			PH_VALUE:   c.item.tag = TAG_VALUE;
			PH_NAME: begin
				if (!lhc && hc >= mx) begin
					c.item = mk(TAG_ERROR, 8'd0, hc, ERR_TOO_MANY);
					c.ph   = PH_ERROR;
				end else begin
					c.lhc      = 1'b1;
					c.item.tag = TAG_NAME;
				end
			end
			default: c.emit = 1'b0;
		endcase
		return c;
	endfunction

	logic [2:0] ph;
	logic       cr;
	logic [7:0] hc;
	logic       lhc;
	logic [1:0] n;
	out_item_t  r0, r1;
	logic       done;
	ct_t        c;
	logic [7:0] b;

	always_comb begin
		ph   = phase_q;
		cr   = cr_q;
		hc   = hc_q;
		lhc  = lhc_q;
		n    = 2'd0;
		r0   = mk(TAG_METHOD, 8'd0, 8'd0, ERR_NONE);
		r1   = r0;
		done = 1'b0;
		b    = in_item.data_byte;
		c    = content(phase_q, lhc_q, hc_q, max_q, CHAR_CR);
		if (in_item.kind == KIND_RESTART) begin
			ph  = PH_METHOD;
			cr  = 1'b0;
			hc  = 8'd0;
			lhc = 1'b0;
		end else if (phase_q != PH_ERROR) begin
			if (cr) begin
				cr = 1'b0;
				if (b == CHAR_LF) begin
					done = 1'b1;
					n    = 2'd1;
					unique case (ph)
						PH_METHOD, PH_URI: begin
							r0 = mk(TAG_ERROR, 8'd0, hc, ERR_NO_SPACE);
							ph = PH_ERROR;
						end
						PH_VERSION: begin
							r0  = mk(TAG_SEP, 8'd0, hc, ERR_NONE);
							ph  = PH_NAME;
							lhc = 1'b0;
						end
						PH_NAME: begin
							if (lhc) begin
								r0 = mk(TAG_ERROR, 8'd0, hc, ERR_NO_COLON);
								ph = PH_ERROR;
							end else begin
								r0  = mk(TAG_DONE, 8'd0, hc, ERR_NONE);
								ph  = PH_METHOD;
								hc  = 8'd0;
								lhc = 1'b0;
							end
						end
						PH_SKIP, PH_VALUE: begin
							r0 = mk(TAG_SEP, 8'd0, hc, ERR_NONE);
							if (hc != 8'hff)
								hc = hc + 8'd1;
							ph  = PH_NAME;
							lhc = 1'b0;
						end
						default: n = 2'd0;
					endcase
				end else begin
					// flush the held CR as content first
					c   = content(ph, lhc, hc, max_q, CHAR_CR);
					ph  = c.ph;
					lhc = c.lhc;
					if (c.emit) begin
						r0 = c.item;
						n  = 2'd1;
					end
					if (ph == PH_ERROR)
						done = 1'b1;
				end
			end
			if (!done) begin
				c = content(ph, lhc, hc, max_q, b);
				if (b == CHAR_NUL) begin
					c.emit = 1'b1;
					c.item = mk(TAG_ERROR, 8'd0, hc, ERR_NUL);
					c.ph   = PH_ERROR;
					c.lhc  = lhc;
				end else if (b == CHAR_CR) begin
					c.emit = 1'b0;
					c.ph   = (ph == PH_SKIP) ? PH_VALUE : ph;
					c.lhc  = lhc;
					cr     = 1'b1;
				end else begin
					priority if ((ph == PH_METHOD || ph == PH_URI) && b == CHAR_SPACE) begin
						c.item = mk(TAG_SEP, 8'd0, hc, ERR_NONE);
						c.ph   = ph + 3'd1;
						c.lhc  = lhc;
					end else if (ph == PH_NAME && b == CHAR_COLON) begin
						c.item = mk(TAG_SEP, 8'd0, hc, ERR_NONE);
						c.ph   = PH_SKIP;
						c.lhc  = 1'b1;
					end else if (ph == PH_SKIP) begin
						// drop the byte after the colon
						c.emit = 1'b0;
						c.ph   = PH_VALUE;
						c.lhc  = lhc;
					end else begin
						c.lhc = c.lhc;
					end
				end
				ph  = c.ph;
				lhc = c.lhc;
				if (c.emit) begin
					if (n == 2'd0) begin
						r0 = c.item;
						n  = 2'd1;
					end else begin
						r1 = c.item;
						n  = 2'd2;
					end
				end
			end
		end
		r0.last_of_run = (n == 2'd1);
		r1.last_of_run = 1'b1;
	end

	assign pair_valid = in_valid && (n != 2'd0);
	assign pair.two   = (n == 2'd2);
	assign pair.r0    = r0;
	assign pair.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			cr_q    <= 1'b0;
			hc_q    <= 8'd0;
			lhc_q   <= 1'b0;
			max_q   <= MAX_HEADERS_RESET;
		end else begin
			if (in_valid) begin
				phase_q <= ph;
				cr_q    <= cr;
				hc_q    <= hc;
				lhc_q   <= lhc;
			end
			if (cfg_we)
				max_q <= cfg_data;
		end
	end

endmodule

// ===== hw/rtl/htok_queue.sv =====
// Short queue of result pairs between the front and back parts.
// Depends on htok_pkg.
module htok_queue
	import htok_pkg::*;
#(
	parameter int DEPTH = HTOK_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  pair_t wr_data,
	output logic  full,
	input  logic  rd,
	output pair_t rd_data,
	output logic  nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_t         mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= nxt(wp_q);
			if (rd)
				rp_q <= nxt(rp_q);
			if (wr && !rd)
				cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== hw/rtl/htok_back.sv =====
// Back part: output register that hands out the results of each pair
// one at a time. Depends on htok_pkg.
module htok_back
	import htok_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_nonempty,
	input  pair_t     q_data,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	pair_t pair_q;
	logic  valid_q;
	logic  sel_q;
	logic  take;
	logic  retire;

	assign retire = pop && valid_q && (sel_q || !pair_q.two);
	assign take   = q_nonempty && (!valid_q || retire);
	assign q_rd   = take;
	assign empty  = !valid_q;
	assign result = sel_q ? pair_q.r1 : pair_q.r0;

	always_ff @(posedge clk) begin
		if (take)
			pair_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				sel_q   <= 1'b0;
			end else if (retire) begin
				valid_q <= 1'b0;
				sel_q   <= 1'b0;
			end else if (pop && valid_q) begin
				// advance to the second result of the pair
				sel_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/htok_checker.sv =====
// Port-level checks for the HTTP request header tokenizer, bound to the
// top level. Depends on htok_pkg.
module htok_checker
	import htok_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// a waiting result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tag == TAG_ERROR |-> result.error_code != ERR_NONE)
		else $error("error result without code");

	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tag != TAG_ERROR |-> result.error_code == ERR_NONE)
		else $error("error code on non-error result");

	a_markers: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.tag == TAG_SEP || result.tag == TAG_DONE ||
		result.tag == TAG_ERROR) |-> result.out_byte == 8'd0 && result.last_of_run)
		else $error("marker result carries a byte or is not last");

endmodule

bind http_request_header_tokenizer htok_checker u_htok_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ===== tb/sv/tb_http_request_header_tokenizer.sv =====
// Self-checking bench for http_request_header_tokenizer: drives byte streams of
// requests, predicts the tagged tokens with its own parser and checks every result.
// Depends on htok_pkg and the tokenizer RTL.
module tb_http_request_header_tokenizer
	import htok_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	in_item_t   item = '0;
	logic       push = 1'b0;
	logic       full;
	out_item_t  result;
	logic       empty;
	logic       pop = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	http_request_header_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	in_item_t  byte_stream[$];
	out_item_t expected_tokens[$];
	out_item_t byte_tokens[$];
	bit        calm = 1'b0;
	int        queued = 0;
	int        fails = 0;
	int        n_items = 0;
	int        n_restarts = 0;
	int        n_results = 0;
	int        n_cfg = 0;
	int        quiet = 0;

	// parser state mirrored from the block
	logic [2:0] phase = PH_METHOD;
	bit         cr_held = 1'b0;
	logic [7:0] hdr_count = '0;
	bit         line_busy = 1'b0;
	logic [7:0] max_hdr = MAX_HEADERS_RESET;

	function automatic void emit(logic [2:0] t, logic [7:0] b, logic [2:0] code);
		out_item_t r;
		if (byte_tokens.size() >= 2)
			return;
		r.tag = t;
		r.out_byte = b;
		r.header_number = hdr_count;
		r.error_code = code;
		r.last_of_run = 1'b0;
		byte_tokens.push_back(r);
	endfunction

	function automatic void raise_error(logic [2:0] code);
		emit(TAG_ERROR, 8'h00, code);
		phase = PH_ERROR;
		cr_held = 1'b0;
	endfunction

	function automatic void tag_content(logic [7:0] b);
		case (phase)
			PH_METHOD: emit(TAG_METHOD, b, ERR_NONE);
			PH_URI: emit(TAG_URI, b, ERR_NONE);
			PH_VERSION: emit(TAG_VERSION, b, ERR_NONE);
			PH_NAME: begin
				// a new header line past the limit is refused
				if (!line_busy && hdr_count >= max_hdr) begin
					raise_error(ERR_TOO_MANY);
				end else begin
					line_busy = 1'b1;
					emit(TAG_NAME, b, ERR_NONE);
				end
			end
			PH_VALUE: emit(TAG_VALUE, b, ERR_NONE);
			default: ;
		endcase
	endfunction

	function automatic void end_line();
		case (phase)
			PH_METHOD, PH_URI: raise_error(ERR_NO_SPACE);
			PH_VERSION: begin
				emit(TAG_SEP, 8'h00, ERR_NONE);
				phase = PH_NAME;
				line_busy = 1'b0;
			end
			PH_NAME: begin
				if (line_busy) begin
					raise_error(ERR_NO_COLON);
				end else begin
					emit(TAG_DONE, 8'h00, ERR_NONE);
					phase = PH_METHOD;
					hdr_count = '0;
					line_busy = 1'b0;
				end
			end
			PH_SKIP, PH_VALUE: begin
				emit(TAG_SEP, 8'h00, ERR_NONE);
				if (hdr_count != 8'hff)
					hdr_count = hdr_count + 8'd1;
				phase = PH_NAME;
				line_busy = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// fill byte_tokens with what one accepted item produces
	function automatic void parse_item(in_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		byte_tokens.delete();
		if (it.kind == KIND_RESTART) begin
			phase = PH_METHOD;
			cr_held = 1'b0;
			hdr_count = '0;
			line_busy = 1'b0;
			return;
		end
		if (phase == PH_ERROR)
			return;
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == CHAR_LF) begin
				end_line();
				return;
			end
			tag_content(CHAR_CR);
			if (phase == PH_ERROR)
				return;
		end
		if (b == CHAR_NUL) begin
			raise_error(ERR_NUL);
			return;
		end
		if (b == CHAR_CR) begin
			if (phase == PH_SKIP)
				phase = PH_VALUE;
			cr_held = 1'b1;
			return;
		end
		case (phase)
			PH_METHOD, PH_URI: begin
				if (b == CHAR_SPACE) begin
					emit(TAG_SEP, 8'h00, ERR_NONE);
					phase = (phase == PH_METHOD) ? PH_URI : PH_VERSION;
				end else begin
					tag_content(b);
				end
			end
			PH_NAME: begin
				if (b == CHAR_COLON) begin
					line_busy = 1'b1;
					emit(TAG_SEP, 8'h00, ERR_NONE);
					phase = PH_SKIP;
				end else begin
					tag_content(b);
				end
			end
			PH_SKIP: phase = PH_VALUE;
			default: tag_content(b);
		endcase
	endfunction

	function automatic void note_failure(string msg);
		fails++;
		if (fails <= REPORT_LIMIT)
			$display("ERROR: %s", msg);
	endfunction

	// driver: one item per handshake, random gaps unless calm
	always @(posedge clk) begin : feed
		bit fire;
		out_item_t r;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			fire = push && !full;
			if (fire) begin
				parse_item(item);
				n_items++;
				if (item.kind == KIND_RESTART)
					n_restarts++;
				foreach (byte_tokens[i]) begin
					r = byte_tokens[i];
					r.last_of_run = (i == byte_tokens.size() - 1);
					expected_tokens.push_back(r);
				end
			end
			if (push && !fire) begin
				// hold the item until it is taken
			end else if (byte_stream.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
				item <= byte_stream.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor: check each popped token against the oldest prediction
	always @(posedge clk) begin : drain
		out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_results++;
				if (expected_tokens.size() == 0) begin
					note_failure($sformatf(
						"unexpected token tag %0d byte %02h hdr %0d err %0d last %0b",
						result.tag, result.out_byte, result.header_number,
						result.error_code, result.last_of_run));
				end else begin
					want = expected_tokens.pop_front();
					if (result.tag !== want.tag || result.out_byte !== want.out_byte ||
						result.header_number !== want.header_number ||
						result.error_code !== want.error_code ||
						result.last_of_run !== want.last_of_run)
						note_failure($sformatf({
							"token %0d: expected tag %0d byte %02h hdr %0d err %0d last %0b,",
							" got tag %0d byte %02h hdr %0d err %0d last %0b"},
							n_results, want.tag, want.out_byte, want.header_number,
							want.error_code, want.last_of_run, result.tag, result.out_byte,
							result.header_number, result.error_code, result.last_of_run));
				end
			end
			pop <= calm || ($urandom_range(99) >= 15);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic put_byte(logic [7:0] b);
		in_item_t it;
		it.kind = KIND_DATA;
		it.data_byte = b;
		byte_stream.push_back(it);
		queued++;
	endtask

	task automatic put_restart();
		in_item_t it;
		it.kind = KIND_RESTART;
		it.data_byte = 8'($urandom_range(255));
		byte_stream.push_back(it);
		queued++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(CHAR_CR);
		put_byte(CHAR_LF);
	endtask

	// content byte from [lo, hi], or any byte at all now and then
	function automatic logic [7:0] text_byte(logic [7:0] lo, logic [7:0] hi, bit noisy);
		if ($urandom_range(99) < (noisy ? 6 : 1))
			return 8'($urandom_range(255));
		return 8'($urandom_range(hi, lo));
	endfunction

	task automatic put_word(int len, logic [7:0] lo, logic [7:0] hi, bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(99) < 2)
				put_restart();
			put_byte(text_byte(lo, hi, noisy));
		end
	endtask

	task automatic put_request(int hdrs, bit noisy);
		if ($urandom_range(3) != 0)
			put_restart();
		put_word($urandom_range(6, 1), 8'h41, 8'h5a, noisy);
		put_byte(CHAR_SPACE);
		put_word($urandom_range(8, 1), 8'h21, 8'h7e, noisy);
		put_byte(CHAR_SPACE);
		put_word($urandom_range(8, 0), 8'h20, 8'h7e, noisy);
		put_crlf();
		for (int h = 0; h < hdrs; h++) begin
			put_word($urandom_range(6, 0), 8'h41, 8'h7a, noisy);
			// broken line: drop the colon
			if (!(noisy && $urandom_range(2) == 0)) begin
				put_byte(CHAR_COLON);
				case ($urandom_range(9))
					0: put_byte(CHAR_CR);
					1: put_byte(8'($urandom_range(255)));
					default: put_byte(CHAR_SPACE);
				endcase
			end
			put_word($urandom_range(8, 0), 8'h20, 8'h7e, noisy);
			put_crlf();
		end
		put_crlf();
	endtask

	task automatic settle();
		do @(posedge clk);
		while (byte_stream.size() != 0 || push || expected_tokens.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_max_headers(logic [7:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		max_hdr = v;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int budget, int hdr_max);
		int start;
		start = queued;
		while (queued - start < budget)
			put_request($urandom_range(hdr_max, 0), $urandom_range(99) < 30);
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every tag, extremes, held CR cases and each error kind
		put_restart();
		put_byte(8'hff);
		put_text("G /");
		put_byte(CHAR_SPACE);
		put_text("V");
		put_byte(CHAR_CR);
		put_text("x");
		put_crlf();
		put_text("a: b: ");
		put_crlf();
		put_text(":");
		put_crlf();
		put_crlf();
		put_crlf();
		put_text("z");
		put_restart();
		put_text("A");
		put_byte(CHAR_CR);
		put_byte(CHAR_NUL);
		put_restart();
		put_text("M / V");
		put_crlf();
		put_text("n");
		put_crlf();
		settle();

		write_max_headers(8'd1);
		put_restart();
		put_text("M / V");
		put_crlf();
		put_text("h:x");
		put_crlf();
		put_text("h");
		settle();
		random_phase(100, 3);

		write_max_headers(8'd0);
		random_phase(100, 2);

		// top of the limit range
		write_max_headers(8'd255);
		random_phase(90, 4);

		write_max_headers(8'd3);
		calm = 1'b1;
		random_phase(110, 5);
		calm = 1'b0;

		write_max_headers(8'($urandom_range(255)));
		random_phase(110, 6);

		if (expected_tokens.size() != 0)
			note_failure($sformatf("%0d tokens never arrived", expected_tokens.size()));
		$display("Sent %0d bytes and restarts (%0d restarts), checked %0d tokens",
			n_items, n_restarts, n_results);
		$display("Header limit written %0d times, including 0 and 255; %0d failures",
			n_cfg, fails);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
